// ----- hdl/pqp_pkg.sv -----
// ============================================================================
// pqp_pkg: shared types and constants of the phantom queue policer
// Field widths, verdict and register codes, and the command and status
// bundles that join the controller to the datapath.
// ============================================================================
package pqp_pkg;

   // payload field widths
   localparam int unsigned ADDR_W       = 32;
   localparam int unsigned PORT_W       = 16;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned TIME_W       = 48;
   localparam int unsigned LIMIT_W      = 16;
   localparam int unsigned RATE_W       = 32;
   localparam int unsigned VERDICT_W    = 2;
   localparam int unsigned SHAPER_NUM_W = 12;
   localparam int unsigned QUEUE_NUM_W  = 6;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DEST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_DEST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAIN_RATE  = 2'd3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32000;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd65536;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_PASS  = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ADMIT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd2;

   // classification: shaper bank bases, port split at 64
   localparam logic [SHAPER_NUM_W-1:0] BASE_FIRST  = 12'd1;
   localparam logic [SHAPER_NUM_W-1:0] BASE_SECOND = 12'd1025;
   localparam int unsigned PORT_SPLIT = 6;

   // token arithmetic
   localparam int unsigned TOKEN_W = 24;
   localparam logic [TOKEN_W-1:0] TOKEN_CAP = 24'h80_0000;
   localparam int unsigned DIV_CNT_W = 5;

   // shaper byte count: stored signed wide enough to follow wrap on drain
   localparam int unsigned SBYTES_W      = 24;
   localparam int unsigned SBYTES_KEEP_W = 22;

   typedef struct packed {
      logic load_in;
      logic clear_step;
      logic rd_entry;
      logic cap_entry;
      logic mul_lo;
      logic mul_hi;
      logic tok_load;
      logic div_start;
      logic scan_init;
      logic scan_next;
      logic q_upd;
      logic commit;
      logic out_load;
   } pqp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic classified;
      logic over;
      logic shaper_empty;
      logic tok_zero;
      logic round_end;
      logic div_done;
      logic share_zero;
      logic scan_hit;
      logic q_last;
   } pqp_status_type;

endpackage

// ----- hdl/pqp_req_if.sv -----
// ============================================================================
// pqp_req_if: packet request channel
// Valid/ready channel carrying one packet descriptor per transfer.
// ============================================================================
interface pqp_req_if import pqp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] dest_address;
   logic [PORT_W-1:0] source_port;
   logic [LEN_W-1:0]  packet_length;
   logic [TIME_W-1:0] current_time;

   modport source (output valid, dest_address, source_port, packet_length, current_time,
                   input ready);
   modport sink   (input valid, dest_address, source_port, packet_length, current_time,
                   output ready);
endinterface

// ----- hdl/pqp_rsp_if.sv -----
// ============================================================================
// pqp_rsp_if: policing result channel
// Valid/ready channel carrying one verdict per transfer.
// ============================================================================
interface pqp_rsp_if import pqp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [VERDICT_W-1:0]    verdict;
   logic [SHAPER_NUM_W-1:0] shaper_number;
   logic [QUEUE_NUM_W-1:0]  queue_number;

   modport source (output valid, verdict, shaper_number, queue_number, input ready);
   modport sink   (input valid, verdict, shaper_number, queue_number, output ready);
endinterface

// ----- hdl/pqp_ram.sv -----
// ============================================================================
// pqp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module pqp_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

// ----- hdl/pqp_div.sv -----
// ============================================================================
// pqp_div: restoring divider for the per-round token share
// One quotient bit per cycle; done pulses when the quotient is ready.
// ============================================================================
module pqp_div import pqp_pkg::*; #(
   parameter int unsigned DIVISOR_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TOKEN_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [TOKEN_W-1:0]   quotient
);
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] div_ff;
   logic [TOKEN_W-1:0]   quo_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   // trial subtraction of the next dividend bit
   assign trial = {rem_ff, quo_ff[TOKEN_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(TOKEN_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? DIVISOR_W'(trial - {1'b0, div_ff}) : trial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[TOKEN_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- hdl/pqp_ctrl.sv -----
// ============================================================================
// pqp_ctrl: policer sequencer
// Steps each packet through lookup, drain rounds, commit and reply.
// ============================================================================
module pqp_ctrl import pqp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  pqp_status_type status,
   output pqp_cmd_type    cmd,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready
);
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_EVAL   = 4'd4;
   localparam logic [3:0] ST_MUL_LO = 4'd5;
   localparam logic [3:0] ST_MUL_HI = 4'd6;
   localparam logic [3:0] ST_TOKENS = 4'd7;
   localparam logic [3:0] ST_ROUND  = 4'd8;
   localparam logic [3:0] ST_DIVIDE = 4'd9;
   localparam logic [3:0] ST_SCAN   = 4'd10;
   localparam logic [3:0] ST_UPDATE = 4'd11;
   localparam logic [3:0] ST_COMMIT = 4'd12;
   localparam logic [3:0] ST_REPLY  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (status.classified) begin
               cmd.rd_entry = 1'b1;
               state_in     = ST_CHECK;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_CHECK: begin
            cmd.cap_entry = 1'b1;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            if (!status.over || status.shaper_empty) state_in = ST_COMMIT;
            else                                     state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_TOKENS;
         end
         ST_TOKENS: begin
            cmd.tok_load = 1'b1;
            state_in     = status.tok_zero ? ST_COMMIT : ST_ROUND;
         end
         ST_ROUND: begin
            if (status.round_end) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.share_zero) begin
                  state_in = ST_COMMIT;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_hit) begin
               cmd.rd_entry = 1'b0;
               state_in     = ST_UPDATE;
            end else if (status.q_last) begin
               state_in = ST_ROUND;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.q_upd = 1'b1;
            state_in  = status.q_last ? ST_ROUND : ST_SCAN;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- hdl/pqp_dp.sv -----
// ============================================================================
// pqp_dp: policer datapath
// Configuration, packet registers, state memories, token math, drain update.
// ============================================================================
module pqp_dp import pqp_pkg::*; #(
   parameter int unsigned QUEUES_PER_SHAPER = 64,
   parameter int unsigned SHAPER_COUNT      = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pqp_cmd_type             cmd,
   output pqp_status_type          status,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data,
   input  logic [ADDR_W-1:0]       in_dest_address,
   input  logic [PORT_W-1:0]       in_source_port,
   input  logic [LEN_W-1:0]        in_packet_length,
   input  logic [TIME_W-1:0]       in_current_time,
   output logic [VERDICT_W-1:0]    out_verdict,
   output logic [SHAPER_NUM_W-1:0] out_shaper_number,
   output logic [QUEUE_NUM_W-1:0]  out_queue_number
);
   localparam int unsigned QW     = $clog2(QUEUES_PER_SHAPER);
   localparam int unsigned SW     = $clog2(SHAPER_COUNT);
   localparam int unsigned QDEPTH = SHAPER_COUNT * QUEUES_PER_SHAPER;
   localparam int unsigned QA     = $clog2(QDEPTH);
   localparam int unsigned NW     = $clog2(QUEUES_PER_SHAPER + 1);

   // configuration registers
   logic [ADDR_W-1:0]  first_ff, second_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [RATE_W-1:0]  rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         limit_ff  <= LIMIT_RESET;
         rate_ff   <= RATE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_DEST:  first_ff  <= csr_write_data;
            CSR_SECOND_DEST: second_ff <= csr_write_data;
            CSR_QUEUE_LIMIT: limit_ff  <= csr_write_data[LIMIT_W-1:0];
            CSR_DRAIN_RATE:  rate_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // packet registers
   logic [ADDR_W-1:0] dest_ff;
   logic [PORT_W-1:0] port_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [TIME_W-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         dest_ff <= in_dest_address;
         port_ff <= in_source_port;
         len_ff  <= in_packet_length;
         now_ff  <= in_current_time;
      end
   end

   // classification
   logic                    match_first, match_second;
   logic [SHAPER_NUM_W-1:0] shaper_num;
   logic [QUEUE_NUM_W-1:0]  queue_num;
   logic                    classified;
   logic [SW-1:0]           s_idx;
   logic [QW-1:0]           q_idx;
   logic [QA-1:0]           entry_addr;

   assign match_first  = dest_ff == first_ff;
   assign match_second = dest_ff == second_ff;
   assign shaper_num   = (match_first ? BASE_FIRST : BASE_SECOND)
                       + SHAPER_NUM_W'(port_ff[PORT_W-1:PORT_SPLIT]);
   assign queue_num    = port_ff[QUEUE_NUM_W-1:0];
   assign classified   = (match_first || match_second)
                       && ({1'b0, shaper_num} <= (SHAPER_NUM_W+1)'(SHAPER_COUNT))
                       && (32'(queue_num) < QUEUES_PER_SHAPER);
   assign s_idx        = SW'(shaper_num - 1'b1);
   assign q_idx        = QW'(queue_num);
   assign entry_addr   = QA'(s_idx) * QA'(QUEUES_PER_SHAPER) + QA'(q_idx);

   // clearing sweep counter
   logic [QA-1:0] clr_ff;
   logic          clr_shaper;

   always_ff @(posedge clock) begin
      if (reset)               clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end
   assign clr_shaper = cmd.clear_step && (clr_ff < QA'(SHAPER_COUNT));

   // working copies of the entry
   logic [LEN_W-1:0]             qb_ff;
   logic [QUEUES_PER_SHAPER-1:0] amap_ff;
   logic [SBYTES_W-1:0]          sb_ff;
   logic [TIME_W-1:0]            lt_ff;
   logic [QA-1:0]                base_ff;
   logic [QW-1:0]                q_ff;
   logic [QUEUES_PER_SHAPER-1:0] smap_ff;
   logic [TOKEN_W-1:0]           tokens_ff;
   logic [63:0]                  lo_ff;
   logic [47:0]                  hi_ff;
   logic                         admit_ff;

   logic [QA-1:0] scan_addr;
   assign scan_addr = base_ff + QA'(q_ff);

   // memories
   logic [LEN_W-1:0]             q_rdata;
   logic [QUEUES_PER_SHAPER-1:0] am_rdata;
   logic [SBYTES_W-1:0]          sb_rdata;
   logic [TIME_W-1:0]            t_rdata;

   logic                         fits;
   logic [LEN_W-1:0]             qb_admit;
   logic [QUEUES_PER_SHAPER-1:0] am_commit;
   logic [SBYTES_W-1:0]          sb_commit;
   logic [SBYTES_KEEP_W-1:0]     sb_sum;
   logic [LEN_W-1:0]             q_new;
   logic [TOKEN_W-1:0]           sub;
   logic                         bigger;
   logic [TOKEN_W-1:0]           tok_calc;
   logic [TOKEN_W-1:0]           share;

   logic                q_we;
   logic [QA-1:0]       q_waddr;
   logic [LEN_W-1:0]    q_wdata;
   logic [SW-1:0]       sh_waddr;

   assign q_we    = cmd.clear_step || cmd.q_upd || (cmd.commit && fits);
   assign q_waddr = cmd.clear_step ? clr_ff : (cmd.q_upd ? scan_addr : base_ff + QA'(q_idx));
   assign q_wdata = cmd.clear_step ? '0 : (cmd.q_upd ? q_new : qb_admit);
   assign sh_waddr = cmd.clear_step ? clr_ff[SW-1:0] : s_idx;

   pqp_ram #(.WIDTH(LEN_W), .DEPTH(QDEPTH)) u_queue_ram (
      .clock(clock), .write_enable(q_we), .write_address(q_waddr), .write_data(q_wdata),
      .read_address(cmd.rd_entry ? entry_addr : scan_addr), .read_data(q_rdata));

   pqp_ram #(.WIDTH(QUEUES_PER_SHAPER), .DEPTH(SHAPER_COUNT)) u_active_ram (
      .clock(clock), .write_enable(clr_shaper || cmd.commit), .write_address(sh_waddr),
      .write_data(cmd.clear_step ? '0 : am_commit),
      .read_address(s_idx), .read_data(am_rdata));

   pqp_ram #(.WIDTH(SBYTES_W), .DEPTH(SHAPER_COUNT)) u_sbytes_ram (
      .clock(clock), .write_enable(clr_shaper || cmd.commit), .write_address(sh_waddr),
      .write_data(cmd.clear_step ? '0 : sb_commit),
      .read_address(s_idx), .read_data(sb_rdata));

   pqp_ram #(.WIDTH(TIME_W), .DEPTH(SHAPER_COUNT)) u_time_ram (
      .clock(clock),
      .write_enable(clr_shaper || (cmd.tok_load && tok_calc != '0)),
      .write_address(sh_waddr), .write_data(cmd.clear_step ? '0 : now_ff),
      .read_address(s_idx), .read_data(t_rdata));

   // overflow test and admission values
   logic [LEN_W:0] need;
   assign need      = {1'b0, qb_ff} + {1'b0, len_ff};
   assign fits      = need <= {1'b0, limit_ff};
   assign qb_admit  = need[LEN_W-1:0];
   assign sb_sum    = SBYTES_KEEP_W'(sb_ff + SBYTES_W'(len_ff));
   assign am_commit = (fits && qb_ff == '0)
                    ? (amap_ff | (QUEUES_PER_SHAPER'(1) << q_idx)) : amap_ff;
   assign sb_commit = fits ? SBYTES_W'(sb_sum) : sb_ff;

   // token count from rate and elapsed time
   logic [TIME_W-1:0] elapsed;
   logic [48:0]       tsum;
   assign elapsed  = now_ff - lt_ff;
   assign tsum     = {hi_ff[32:0], 16'b0} + 49'(lo_ff[63:16]);
   assign tok_calc = (hi_ff >= 48'(TOKEN_CAP) || tsum > 49'(TOKEN_CAP))
                   ? TOKEN_CAP : tsum[TOKEN_W-1:0];

   // active queue count
   logic [NW-1:0] n_active;
   always_comb begin
      n_active = '0;
      for (int i = 0; i < QUEUES_PER_SHAPER; i++) begin
         n_active = n_active + NW'(amap_ff[i]);
      end
   end

   logic div_done;
   pqp_div #(.DIVISOR_W(NW)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(tokens_ff),
      .divisor(n_active), .done(div_done), .quotient(share));

   // drain step on one queue
   assign bigger = {{(TOKEN_W-LEN_W){1'b0}}, q_rdata} > share;
   assign q_new  = bigger ? q_rdata - share[LEN_W-1:0] : '0;
   assign sub    = bigger ? share : TOKEN_W'(q_rdata);

   always_ff @(posedge clock) begin
      if (cmd.cap_entry) begin
         qb_ff   <= q_rdata;
         amap_ff <= am_rdata;
         sb_ff   <= sb_rdata;
         lt_ff   <= t_rdata;
         base_ff <= QA'(s_idx) * QA'(QUEUES_PER_SHAPER);
      end else if (cmd.q_upd) begin
         sb_ff <= sb_ff - SBYTES_W'(sub);
         if (!bigger) amap_ff[q_ff] <= 1'b0;
         if (q_ff == q_idx) qb_ff <= q_new;
      end else if (cmd.commit) begin
         amap_ff <= am_commit;
         sb_ff   <= sb_commit;
      end
      if (cmd.mul_lo) lo_ff <= 64'(rate_ff) * 64'(elapsed[31:0]);
      if (cmd.mul_hi) hi_ff <= 48'(rate_ff) * 48'(elapsed[47:32]);
      if (cmd.tok_load)   tokens_ff <= tok_calc;
      else if (cmd.q_upd) tokens_ff <= tokens_ff - sub;
      if (cmd.scan_init) begin
         smap_ff <= amap_ff;
         q_ff    <= '0;
      end else if (cmd.scan_next || cmd.q_upd) begin
         q_ff <= q_ff + 1'b1;
      end
      if (cmd.commit) admit_ff <= fits;
   end

   // result register
   logic [VERDICT_W-1:0]    verdict_ff;
   logic [SHAPER_NUM_W-1:0] shaper_ff;
   logic [QUEUE_NUM_W-1:0]  queue_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         verdict_ff <= !classified ? VERDICT_PASS : (admit_ff ? VERDICT_ADMIT : VERDICT_DROP);
         shaper_ff  <= classified ? shaper_num : '0;
         queue_ff   <= classified ? queue_num : '0;
      end
   end

   assign out_verdict       = verdict_ff;
   assign out_shaper_number = shaper_ff;
   assign out_queue_number  = queue_ff;

   // status to the sequencer
   assign status.clear_last   = clr_ff == QA'(QDEPTH - 1);
   assign status.classified   = classified;
   assign status.over         = !fits;
   assign status.shaper_empty = sb_ff == '0;
   assign status.tok_zero     = tok_calc == '0;
   assign status.round_end    = tokens_ff == '0 || sb_ff == '0 || n_active == '0;
   assign status.div_done     = div_done;
   assign status.share_zero   = share == '0;
   assign status.scan_hit     = smap_ff[q_ff];
   assign status.q_last       = q_ff == QW'(QUEUES_PER_SHAPER - 1);
endmodule

// ----- hdl/phantom_queue_policer.sv -----
// ============================================================================
// phantom_queue_policer: per-queue phantom byte policer
// Classifies packets to a shaper and queue and admits or drops them.
// ============================================================================
// After reset the block sweeps its state memories, one queue entry a cycle,
// over all SHAPER_COUNT*QUEUES_PER_SHAPER entries, and takes no packet
// meanwhile; configuration writes are taken at any time. Packets are handled
// one at a time. An unclassified packet goes from the read state to the
// reply; one that fits its queue passes the check, evaluate and commit
// states first. The block is ready again in the same cycle as the result
// becomes valid. A packet that overflows a non-empty shaper adds the token
// multiply (partial products over the low 32 and high 16 bits of the elapsed
// time) and the token load. Each water-filling round then runs the round
// check and the share division (one quotient bit a cycle), and walks every
// queue, with an update step after each active one, the queue memory read
// port setting that walk. The drain ends with one more round check, or at a
// division whose share is zero. A finished result is held in an output
// register, so the next packet is taken while it waits.
module phantom_queue_policer import pqp_pkg::*; #(
   parameter int unsigned QUEUES_PER_SHAPER = 64,
   parameter int unsigned SHAPER_COUNT      = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   pqp_req_if.sink               req_bus,
   pqp_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   pqp_cmd_type    cmd;
   pqp_status_type status;

   pqp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready));

   pqp_dp #(.QUEUES_PER_SHAPER(QUEUES_PER_SHAPER), .SHAPER_COUNT(SHAPER_COUNT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .in_dest_address(req_bus.dest_address), .in_source_port(req_bus.source_port),
      .in_packet_length(req_bus.packet_length), .in_current_time(req_bus.current_time),
      .out_verdict(rsp_bus.verdict), .out_shaper_number(rsp_bus.shaper_number),
      .out_queue_number(rsp_bus.queue_number));
endmodule

// ----- dv/phantom_queue_policer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// phantom_queue_policer_tb: self-checking bench for the phantom queue policer
// Packets go in on the request channel and verdicts are compared one by one
// with a behavioral model of classification, the phantom byte counts and the
// water-filling drain. The run covers directed corners, then random traffic
// over several register settings, with random stalls on both channels.
// ============================================================================
module phantom_queue_policer_tb;
   import pqp_pkg::*;

   localparam int unsigned QPS         = 64;
   localparam int unsigned SHAPERS     = 2048;
   localparam int unsigned WATCHDOG    = 600000;
   localparam int unsigned SETTLE      = 20;
   localparam int unsigned CAP_TOKENS  = 1 << 23;

   typedef struct packed {
      logic [VERDICT_W-1:0]    verdict;
      logic [SHAPER_NUM_W-1:0] shaper_number;
      logic [QUEUE_NUM_W-1:0]  queue_number;
   } verdict_rec_type;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pqp_req_if req_bus ();
   pqp_rsp_if rsp_bus ();

   phantom_queue_policer #(.QUEUES_PER_SHAPER(QPS), .SHAPER_COUNT(SHAPERS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // policer model state and registers
   bit [31:0] cfg_first_dest;
   bit [31:0] cfg_second_dest;
   bit [15:0] cfg_queue_limit = LIMIT_RESET;
   bit [31:0] cfg_drain_rate  = RATE_RESET;
   bit [15:0] queue_bytes_m [SHAPERS*QPS];
   bit [63:0] active_map_m  [SHAPERS];
   int unsigned shaper_bytes_m [SHAPERS];
   bit [47:0] last_drain_m  [SHAPERS];

   verdict_rec_type pending_verdicts[$];
   int  errors;
   int  n_pass, n_admit, n_drop;
   bit  idle_on;
   int  idle_cycles;
   int  rsp_stall_left;
   bit [47:0] now_ticks;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // water-filling drain of one shaper
   function automatic void drain_shaper(int unsigned s, bit [47:0] now);
      bit [47:0]  elapsed;
      bit [95:0]  prod;
      longint unsigned tokens, share;
      bit [63:0]  map;
      int unsigned n, idx;
      if (shaper_bytes_m[s] == 0) return;
      elapsed = now - last_drain_m[s];
      prod = 96'(cfg_drain_rate) * 96'(elapsed);
      prod = prod >> 16;
      tokens = (prod > CAP_TOKENS) ? CAP_TOKENS : longint'(prod);
      if (tokens == 0) return;
      last_drain_m[s] = now;
      while (tokens != 0 && shaper_bytes_m[s] != 0) begin
         map = active_map_m[s];
         n = $countones(map);
         if (n == 0) break;
         share = tokens / n;
         if (share == 0) break;
         for (int q = 0; q < QPS; q++) begin
            idx = s*QPS + q;
            if (!map[q]) continue;
            if (longint'(queue_bytes_m[idx]) > share) begin
               queue_bytes_m[idx] = queue_bytes_m[idx] - 16'(share);
               tokens -= share;
               shaper_bytes_m[s] -= int'(share);
            end else begin
               tokens -= queue_bytes_m[idx];
               shaper_bytes_m[s] -= queue_bytes_m[idx];
               queue_bytes_m[idx] = 0;
               active_map_m[s][q] = 1'b0;
            end
         end
      end
   endfunction

   // classify, drain if needed, then admit or drop
   function automatic verdict_rec_type police_packet(bit [31:0] dst, bit [15:0] port,
                                                     bit [15:0] len, bit [47:0] now);
      verdict_rec_type r;
      int unsigned shaper, q, s, idx;
      shaper = 0;
      if (dst == cfg_first_dest) shaper = 1 + port/64;
      else if (dst == cfg_second_dest) shaper = 1025 + port/64;
      q = port % 64;
      r = '0;
      r.verdict = VERDICT_PASS;
      if (shaper == 0 || shaper > SHAPERS || q >= QPS) return r;
      s = shaper - 1;
      idx = s*QPS + q;
      // sums taken 32 bits wide so a full queue plus a long packet cannot wrap
      if (int'(queue_bytes_m[idx]) + int'(len) > int'(cfg_queue_limit))
         drain_shaper(s, now);
      if (int'(queue_bytes_m[idx]) + int'(len) <= int'(cfg_queue_limit)) begin
         if (queue_bytes_m[idx] == 0) active_map_m[s][q] = 1'b1;
         queue_bytes_m[idx] = queue_bytes_m[idx] + len;
         shaper_bytes_m[s] = (shaper_bytes_m[s] + len) & 32'h3F_FFFF;
         r.verdict = VERDICT_ADMIT;
      end else begin
         r.verdict = VERDICT_DROP;
      end
      r.shaper_number = shaper[SHAPER_NUM_W-1:0];
      r.queue_number  = q[QUEUE_NUM_W-1:0];
      return r;
   endfunction

   // one register write; model follows at once since the block is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_FIRST_DEST:  cfg_first_dest  = data;
         CSR_SECOND_DEST: cfg_second_dest = data;
         CSR_QUEUE_LIMIT: cfg_queue_limit = data[15:0];
         CSR_DRAIN_RATE:  cfg_drain_rate  = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] first, logic [31:0] second,
                            logic [15:0] limit, logic [31:0] rate);
      write_reg(CSR_FIRST_DEST, first);
      write_reg(CSR_SECOND_DEST, second);
      write_reg(CSR_QUEUE_LIMIT, {16'd0, limit});
      write_reg(CSR_DRAIN_RATE, rate);
   endtask

   // wait until every verdict is back, then let the block settle
   task automatic wait_quiet();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one packet transfer; valid stays high into the next packet unless a gap falls
   task automatic send_packet(bit [31:0] dst, bit [15:0] port, bit [15:0] len,
                              bit [47:0] now);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.dest_address  <= dst;
      req_bus.source_port   <= port;
      req_bus.packet_length <= len;
      req_bus.current_time  <= now;
      do @(posedge clock); while (!req_bus.ready);
      pending_verdicts = {pending_verdicts, police_packet(dst, port, len, now)};
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // directed corners
   task automatic test_directed_cases();
      configure(32'h0A00_0001, 32'h0A00_0002, 16'd1000, 32'd65536);
      idle_on = 1'b1;
      send_packet(32'hC0A8_0001, 16'h1234, 16'd100, 48'd5);     // unclassified
      send_packet(32'h0A00_0001, 16'h0000, 16'd0, 48'd10);      // zero length, empty queue
      send_packet(32'h0A00_0001, 16'hFFFF, 16'hFFFF, 48'd10);   // top shaper, empty drain
      send_packet(32'h0A00_0002, 16'hFFFF, 16'd500, 48'd10);    // second bank top
      send_packet(32'h0A00_0001, 16'h0005, 16'd600, 48'd20);
      send_packet(32'h0A00_0001, 16'h0005, 16'd600, 48'd20);    // drain takes tokens
      send_packet(32'h0A00_0001, 16'h0005, 16'd600, 48'd20);    // zero tokens
      send_packet(32'h0A00_0001, 16'h0005, 16'd900, 48'd3);     // time goes backwards
      for (int q = 0; q < 8; q++)
         send_packet(32'h0A00_0001, 16'(64 + q), 16'd100, 48'd100);
      send_packet(32'h0A00_0001, 16'd64, 16'd950, 48'd101);     // zero share stops drain
      send_packet(32'h0A00_0001, 16'd64, 16'd950, 48'd200);
      send_packet(32'h0A00_0002, 16'hFFC0, 16'd1000, 48'd300);  // exactly at limit
      send_packet(32'h0A00_0002, 16'hFFC0, 16'd1, 48'd300);
      end_burst();
      wait_quiet();
      // both addresses equal, extreme rate and limit
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_packet(32'hFFFF_FFFF, 16'h0041, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_packet(32'hFFFF_FFFF, 16'h0041, 16'hFFFF, 48'h0);    // token overflow
      send_packet(32'h0000_0000, 16'h0041, 16'd10, 48'h1);
      end_burst();
      wait_quiet();
   endtask

   // random packets on a few shapers, plus noise
   task automatic random_phase(int items, int unsigned limit_hint);
      bit [15:0] offs [3];
      bit [31:0] dst;
      bit [15:0] port, len;
      int unsigned pick;
      for (int i = 0; i < 3; i++) offs[i] = 16'($urandom_range(0, 1023));
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 9);
         if ($urandom_range(0, 49) == 0) now_ticks = 48'({$urandom, $urandom});
         else now_ticks = now_ticks + 48'($urandom_range(0, 64));
         if (pick < 8) begin
            dst  = $urandom_range(0, 1) ? cfg_first_dest : cfg_second_dest;
            port = {offs[$urandom_range(0, 2)][9:0], 6'($urandom_range(0, 7))};
            len  = 16'($urandom_range(0, limit_hint/3 + 1));
         end else begin
            dst  = (pick == 8) ? $urandom : cfg_first_dest;
            port = 16'($urandom);
            len  = 16'($urandom);
         end
         send_packet(dst, port, len, now_ticks);
      end
      end_burst();
      wait_quiet();
   endtask

   task automatic test_random_phases();
      idle_on = 1'b1;
      configure($urandom, $urandom, 16'd2000, 32'd8192);
      random_phase(130, 2000);
      configure(32'h0000_0000, 32'hFFFF_FFFF, 16'd0, 32'd0);
      random_phase(60, 0);
      configure($urandom, $urandom, 16'hFFFF, 32'hFFFF_FFFF);
      random_phase(110, 65535);
      idle_on = $urandom_range(0, 1);
      configure($urandom, $urandom, 16'd500, 32'd65536);
      random_phase(140, 500);
      idle_on = 1'b1;
      configure($urandom, $urandom, 16'($urandom_range(100, 5000)), $urandom_range(1, 300000));
      random_phase(140, 3000);
      configure(32'h5555_AAAA, 32'hAAAA_5555, 16'd4000, 32'd1000);
      random_phase(120, 4000);
   endtask

   // back-to-back traffic with no stalls on either side
   task automatic test_final_burst();
      idle_on = 1'b0;
      configure($urandom, $urandom, 16'd1500, 32'd20000);
      random_phase(130, 1500);
   endtask

   // result checker and response stalls
   always @(posedge clock) begin
      verdict_rec_type exp_v;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected verdict transfer %0d/%0d/%0d", $time,
                     rsp_bus.verdict, rsp_bus.shaper_number, rsp_bus.queue_number);
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_bus.verdict !== exp_v.verdict) begin
               errors++;
               $display("%0t: verdict expected %0d actual %0d", $time,
                        exp_v.verdict, rsp_bus.verdict);
            end
            if (rsp_bus.shaper_number !== exp_v.shaper_number) begin
               errors++;
               $display("%0t: shaper expected %0d actual %0d", $time,
                        exp_v.shaper_number, rsp_bus.shaper_number);
            end
            if (rsp_bus.queue_number !== exp_v.queue_number) begin
               errors++;
               $display("%0t: queue expected %0d actual %0d", $time,
                        exp_v.queue_number, rsp_bus.queue_number);
            end
            case (exp_v.verdict)
               VERDICT_PASS:  n_pass++;
               VERDICT_ADMIT: n_admit++;
               default:       n_drop++;
            endcase
         end
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
         $display("phantom_queue_policer_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FIRST_DEST;
      csr_write_data   = '0;
      req_bus.valid         = 1'b0;
      req_bus.dest_address  = '0;
      req_bus.source_port   = '0;
      req_bus.packet_length = '0;
      req_bus.current_time  = '0;
      rsp_bus.ready    = 1'b1;
      errors = 0; n_pass = 0; n_admit = 0; n_drop = 0;
      idle_cycles = 0; rsp_stall_left = 0; now_ticks = '0; idle_on = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_phases();
      test_final_burst();
      $display("Checked %0d verdicts: %0d passed, %0d admitted, %0d dropped,",
               n_pass + n_admit + n_drop, n_pass, n_admit, n_drop);
      $display("over limits 0..65535, drain rates 0..max, with and without stalls.");
      if (errors == 0)
         $display("phantom_queue_policer_tb OK");
      else
         $display("phantom_queue_policer_tb NOT OK");
      $finish;
   end

endmodule
